// ===== rtl/core/gffs_pkg.sv =====
// ----------------------------------------------------------------------------
// gffs_pkg
// Shared types and constants of the FIRST / FOLLOW set engine.
// ----------------------------------------------------------------------------
package gffs_pkg;

	localparam int unsigned NT       = 26;
	localparam int unsigned SET_W    = 256;
	localparam int unsigned ROWS     = 2 * NT;
	localparam int unsigned ROW_AW   = 6;
	localparam logic [7:0]  EPS_CODE = 8'h23;
	localparam logic [7:0]  END_CODE = 8'h24;
	localparam logic [7:0]  LETTER_A = 8'h41;

	typedef enum logic [1:0] {
		MODE_LOAD    = 2'd0,
		MODE_COMPUTE = 2'd1,
		MODE_QUERY   = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MOP_HOLD    = 2'd0,
		MOP_ADD     = 2'd1,
		MOP_OR      = 2'd2,
		MOP_OR_NEPS = 2'd3
	} merge_op_t;

	typedef struct packed {
		merge_op_t  op;
		logic [7:0] code;
	} merge_req_t;

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= LETTER_A) && (c < LETTER_A + 8'(NT));
	endfunction

	// Set row of a letter: FIRST rows first, FOLLOW rows after them
	function automatic logic [ROW_AW-1:0] letter_row(input logic [7:0] c, input logic fol);
		logic [7:0] r;
		r = (c - LETTER_A) + (fol ? 8'(NT) : 8'd0);
		return r[ROW_AW-1:0];
	endfunction

endpackage

// ===== rtl/core/gffs_ram.sv =====
// ----------------------------------------------------------------------------
// gffs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module gffs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/core/gffs_merge.sv =====
// ----------------------------------------------------------------------------
// gffs_merge
// Shared set unit: add one code to a 256-bit set, or OR a set row into it with its eps bit kept or masked.
// ----------------------------------------------------------------------------
module gffs_merge import gffs_pkg::*; (
	input  merge_req_t        req,
	input  logic [SET_W-1:0]  acc,
	input  logic [SET_W-1:0]  row,
	output logic [SET_W-1:0]  acc_out,
	output logic              row_eps
);
	logic [SET_W-1:0] code_bit;
	logic [SET_W-1:0] eps_mask;

	assign code_bit = SET_W'(1) << req.code;
	assign eps_mask = ~(SET_W'(1) << EPS_CODE);
	assign row_eps  = row[EPS_CODE];

	// Select the combine operation
	always_comb begin
		case (req.op)
			MOP_ADD:     acc_out = acc | code_bit;
			MOP_OR:      acc_out = acc | row;
			MOP_OR_NEPS: acc_out = acc | (row & eps_mask);
			default:     acc_out = acc;
		endcase
	end
endmodule

// ===== rtl/core/grammar_first_follow_sets.sv =====
// ----------------------------------------------------------------------------
// grammar_first_follow_sets
// Loads grammar productions, computes FIRST and FOLLOW sets to a fixed point
// and answers set queries as four 64-bit membership chunks.
// ----------------------------------------------------------------------------
// channel   | handshake            | fields
// request   | start / busy         | mode symbol end_of_production
//           |                      | nonterminal_index set_select
// result    | result_valid strobe  | set_chunk chunk_index last
//           |                      | is_nonterminal status
//
// Load: accepted while idle, result in the next cycle, busy stays low.
// Query: one set RAM read then four chunks, busy until the last chunk is registered.
// Compute: passes over all productions through one merge unit; each
// right-side symbol is read and merged in turn, and each destination
// set row is read and written back.
// Reset clears counts and the set row valid bits; no clearing pass.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module grammar_first_follow_sets import gffs_pkg::*; #(
	parameter int unsigned MAX_PRODUCTIONS = 64,
	parameter int unsigned MAX_SYMBOLS     = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [7:0]  symbol,
	input  logic        end_of_production,
	input  logic [4:0]  nonterminal_index,
	input  logic        set_select,
	output logic        result_valid,
	output logic [63:0] set_chunk,
	output logic [1:0]  chunk_index,
	output logic        last,
	output logic        is_nonterminal,
	output logic [1:0]  status
);
	localparam int unsigned PW  = (MAX_PRODUCTIONS > 1) ? $clog2(MAX_PRODUCTIONS) : 1;
	localparam int unsigned CW  = $clog2(MAX_PRODUCTIONS + 1);
	localparam int unsigned WW  = $clog2(MAX_SYMBOLS + 1);
	localparam int unsigned SAW = $clog2(MAX_PRODUCTIONS * MAX_SYMBOLS);

	typedef enum logic [4:0] {
		S_IDLE, S_QRD, S_QOUT, S_CINIT, S_PSTART, S_LHS, S_BSCAN, S_BSYM,
		S_ACC, S_WALK, S_SYM, S_XROW, S_VAN, S_FAROW, S_WB, S_PEND,
		S_SEED, S_SEEDRD, S_SEEDWB
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    count_q;
	logic [WW-1:0]    wpos_q;
	logic [NT-1:0]    seen_q;
	logic [ROWS-1:0]  row_valid_q;
	logic             rd_valid_q;
	logic             changed_q;
	logic             follow_q;
	logic [CW-1:0]    p_q;
	logic [WW-1:0]    j_q;
	logic [WW-1:0]    jb_q;
	logic [WW-1:0]    len_q;
	logic [7:0]       a_q;
	logic [ROW_AW-1:0] dst_q;
	logic [SET_W-1:0] acc_q;
	logic [SET_W-1:0] orig_q;
	logic [SET_W-1:0] row_q;
	logic             q_ok_q;
	logic [1:0]       k_q;

	logic [SAW-1:0]    sym_waddr, sym_raddr;
	logic              sym_we;
	logic [7:0]        sym_rd;
	logic              len_we;
	logic [PW-1:0]     len_raddr;
	logic [WW-1:0]     len_rd;
	logic [WW-1:0]     wpos_inc;
	logic [ROW_AW-1:0] set_raddr;
	logic              set_we;
	logic [SET_W-1:0]  set_ram_rd, set_rd;
	merge_req_t        mreq;
	logic [SET_W-1:0]  macc_in, macc_out;
	logic              mrow_eps;
	logic              load_go, load_store;

	assign busy      = (state_q != S_IDLE);
	assign load_go   = start && !busy && (mode == MODE_LOAD) && (count_q < CW'(MAX_PRODUCTIONS));
	assign load_store = load_go && (wpos_q < WW'(MAX_SYMBOLS));
	assign wpos_inc  = load_store ? (wpos_q + 1'b1) : wpos_q;
	assign sym_we    = load_store;
	assign len_we    = load_go && end_of_production;
	assign sym_waddr = SAW'(SAW'(count_q) * SAW'(MAX_SYMBOLS) + SAW'(wpos_q));
	assign set_rd    = rd_valid_q ? set_ram_rd : '0;
	assign set_we    = (state_q == S_WB) || (state_q == S_SEEDWB);

	// Drive read addresses and the merge request from the sequencer
	always_comb begin
		sym_raddr = SAW'(SAW'(p_q) * SAW'(MAX_SYMBOLS));
		len_raddr = p_q[PW-1:0];
		set_raddr = dst_q;
		mreq      = '{op: MOP_HOLD, code: 8'd0};
		macc_in   = acc_q;
		case (state_q)
			S_IDLE: begin
				set_raddr = letter_row(LETTER_A + 8'(nonterminal_index), set_select);
			end
			S_BSCAN: sym_raddr = SAW'(SAW'(p_q) * SAW'(MAX_SYMBOLS) + SAW'(jb_q));
			S_BSYM:  set_raddr = letter_row(sym_rd, 1'b1);
			S_LHS:   set_raddr = letter_row(sym_rd, 1'b0);
			S_WALK:  sym_raddr = SAW'(SAW'(p_q) * SAW'(MAX_SYMBOLS) + SAW'(j_q));
			S_SYM: begin
				set_raddr = letter_row(sym_rd, 1'b0);
				mreq      = '{op: MOP_ADD, code: sym_rd};
			end
			S_XROW:  mreq = '{op: MOP_OR_NEPS, code: 8'd0};
			S_VAN: begin
				set_raddr = letter_row(a_q, 1'b1);
				mreq      = '{op: MOP_ADD, code: EPS_CODE};
			end
			S_FAROW: mreq = '{op: MOP_OR, code: 8'd0};
			S_PEND:  sym_raddr = '0;
			S_SEED:  set_raddr = letter_row(sym_rd, 1'b1);
			S_SEEDRD: begin
				mreq    = '{op: MOP_ADD, code: END_CODE};
				macc_in = set_rd;
			end
			default: ;
		endcase
	end

	gffs_ram #(.WIDTH(8), .DEPTH(MAX_PRODUCTIONS * MAX_SYMBOLS)) u_sym_ram (
		.clk(clk), .we(sym_we), .waddr(sym_waddr), .wdata(symbol),
		.raddr(sym_raddr), .rdata(sym_rd)
	);

	gffs_ram #(.WIDTH(WW), .DEPTH(MAX_PRODUCTIONS)) u_len_ram (
		.clk(clk), .we(len_we), .waddr(count_q[PW-1:0]), .wdata(wpos_inc),
		.raddr(len_raddr), .rdata(len_rd)
	);

	gffs_ram #(.WIDTH(SET_W), .DEPTH(ROWS)) u_set_ram (
		.clk(clk), .we(set_we), .waddr(dst_q), .wdata(acc_q),
		.raddr(set_raddr), .rdata(set_ram_rd)
	);

	gffs_merge u_merge (
		.req(mreq), .acc(macc_in), .row(set_rd), .acc_out(macc_out), .row_eps(mrow_eps)
	);

	// Hold state, sequence the passes and register the results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			wpos_q         <= '0;
			seen_q         <= '0;
			row_valid_q    <= '0;
			rd_valid_q     <= 1'b0;
			changed_q      <= 1'b0;
			follow_q       <= 1'b0;
			p_q            <= '0;
			k_q            <= '0;
			result_valid   <= 1'b0;
			set_chunk      <= '0;
			chunk_index    <= '0;
			last           <= 1'b0;
			is_nonterminal <= 1'b0;
			status         <= ST_OK;
		end else begin
			rd_valid_q   <= row_valid_q[set_raddr];
			result_valid <= 1'b0;
			if (set_we) begin
				row_valid_q[dst_q] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						set_chunk      <= '0;
						chunk_index    <= '0;
						last           <= 1'b1;
						is_nonterminal <= 1'b0;
						status         <= ST_OK;
						case (mode)
							MODE_LOAD: begin
								result_valid <= 1'b1;
								if (!load_go || !load_store) begin
									status <= ST_FULL;
								end
								if (load_store && is_upper(symbol)) begin
									seen_q[5'(symbol - LETTER_A)] <= 1'b1;
								end
								if (len_we) begin
									count_q <= count_q + 1'b1;
									wpos_q  <= '0;
								end else if (load_store) begin
									wpos_q <= wpos_inc;
								end
							end
							MODE_COMPUTE: state_q <= S_CINIT;
							MODE_QUERY: begin
								q_ok_q         <= (nonterminal_index < 5'(NT));
								is_nonterminal <= (nonterminal_index < 5'(NT)) &&
									seen_q[nonterminal_index];
								state_q        <= S_QRD;
							end
							default: result_valid <= 1'b1;
						endcase
					end
				end
				S_QRD: begin
					row_q   <= q_ok_q ? set_rd : '0;
					k_q     <= '0;
					state_q <= S_QOUT;
				end
				S_QOUT: begin
					result_valid <= 1'b1;
					set_chunk    <= row_q[64*k_q +: 64];
					chunk_index  <= k_q;
					last         <= (k_q == 2'd3);
					k_q          <= k_q + 1'b1;
					if (k_q == 2'd3) begin
						state_q <= S_IDLE;
					end
				end
				S_CINIT: begin
					row_valid_q <= '0;
					changed_q   <= 1'b0;
					follow_q    <= 1'b0;
					p_q         <= '0;
					if (count_q == '0) begin
						result_valid <= 1'b1;
						status       <= ST_EMPTY;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_PSTART;
					end
				end
				S_PSTART: state_q <= (p_q == count_q) ? S_PEND : S_LHS;
				S_LHS: begin
					a_q   <= sym_rd;
					len_q <= len_rd;
					if (!is_upper(sym_rd)) begin
						p_q     <= p_q + 1'b1;
						state_q <= S_PSTART;
					end else if (!follow_q) begin
						dst_q   <= letter_row(sym_rd, 1'b0);
						j_q     <= WW'(1);
						state_q <= S_ACC;
					end else begin
						jb_q    <= WW'(1);
						state_q <= S_BSCAN;
					end
				end
				S_BSCAN: begin
					if (jb_q >= len_q) begin
						p_q     <= p_q + 1'b1;
						state_q <= S_PSTART;
					end else begin
						state_q <= S_BSYM;
					end
				end
				S_BSYM: begin
					if (!is_upper(sym_rd)) begin
						jb_q    <= jb_q + 1'b1;
						state_q <= S_BSCAN;
					end else begin
						dst_q   <= letter_row(sym_rd, 1'b1);
						j_q     <= jb_q + 1'b1;
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					acc_q   <= set_rd;
					orig_q  <= set_rd;
					state_q <= S_WALK;
				end
				S_WALK: state_q <= (j_q >= len_q) ? S_VAN : S_SYM;
				S_SYM: begin
					if (sym_rd == EPS_CODE) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_WALK;
					end else if (!is_upper(sym_rd)) begin
						acc_q   <= macc_out;
						state_q <= S_WB;
					end else begin
						state_q <= S_XROW;
					end
				end
				S_XROW: begin
					acc_q <= macc_out;
					if (mrow_eps) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_WALK;
					end else begin
						state_q <= S_WB;
					end
				end
				S_VAN: begin
					if (!follow_q) begin
						acc_q   <= macc_out;
						state_q <= S_WB;
					end else begin
						state_q <= S_FAROW;
					end
				end
				S_FAROW: begin
					acc_q   <= macc_out;
					state_q <= S_WB;
				end
				S_WB: begin
					if (acc_q != orig_q) begin
						changed_q <= 1'b1;
					end
					if (!follow_q) begin
						p_q     <= p_q + 1'b1;
						state_q <= S_PSTART;
					end else begin
						jb_q    <= jb_q + 1'b1;
						state_q <= S_BSCAN;
					end
				end
				S_PEND: begin
					p_q       <= '0;
					changed_q <= 1'b0;
					if (changed_q) begin
						state_q <= S_PSTART;
					end else if (!follow_q) begin
						follow_q <= 1'b1;
						state_q  <= S_SEED;
					end else begin
						result_valid <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_SEED: begin
					if (is_upper(sym_rd)) begin
						dst_q   <= letter_row(sym_rd, 1'b1);
						state_q <= S_SEEDRD;
					end else begin
						state_q <= S_PSTART;
					end
				end
				S_SEEDRD: begin
					acc_q   <= macc_out;
					state_q <= S_SEEDWB;
				end
				S_SEEDWB: state_q <= S_PSTART;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/gffs_checker.sv =====
// ----------------------------------------------------------------------------
// gffs_checker
// Port level checks of the set engine, bound to the top level.
// ----------------------------------------------------------------------------
module gffs_checker import gffs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        result_valid,
	input logic [1:0]  chunk_index,
	input logic        last,
	input logic        is_nonterminal,
	input logic [1:0]  status
);
	// Query chunks follow each other in order
	a_chunk_seq: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> result_valid && (chunk_index == $past(chunk_index) + 2'd1))
		else $error("query chunk out of order");

	// A non-final chunk comes only while a query is in progress
	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("chunk outside query");

	// Error status only on single results
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != ST_OK) |-> last && (chunk_index == 2'd0) && !is_nonterminal)
		else $error("error status on query chunk");

	// Reserved status code never appears
	a_no_rsvd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (status != ST_RSVD))
		else $error("reserved status");
endmodule

bind grammar_first_follow_sets gffs_checker u_gffs_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy), .result_valid(result_valid),
	.chunk_index(chunk_index), .last(last), .is_nonterminal(is_nonterminal),
	.status(status)
);

// ===== bench/grammar_first_follow_sets_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grammar_first_follow_sets_tb
// Self-checking bench for the FIRST / FOLLOW set engine: loads grammars
// symbol by symbol, runs computes and queries, and compares every strobed
// result against an in-bench set predictor under random sender idling.
// ----------------------------------------------------------------------------
module grammar_first_follow_sets_tb;
	import gffs_pkg::*;

	localparam int PROD_CAP = 64;
	localparam int SYM_CAP  = 32;

	typedef struct {
		mode_t      m;
		logic [7:0] sym;
		logic       eop;
		logic [4:0] nt;
		logic       sel;
	} request_t;

	typedef struct {
		logic [63:0] chunk;
		logic [1:0]  idx;
		logic        lst;
		logic        isnt;
		status_t     st;
	} chunk_t;

	logic        clk, arst_n, start, busy, end_of_production, set_select;
	logic [1:0]  mode, chunk_index, status;
	logic [7:0]  symbol;
	logic [4:0]  nonterminal_index;
	logic        result_valid, last, is_nonterminal;
	logic [63:0] set_chunk;

	grammar_first_follow_sets uut (.*);

	request_t pending_q[$];
	chunk_t   chunk_q[$];
	int       errors, accepted, n_results, n_computes, n_queries, total_reqs;
	bit       took;

	// Predictor state
	logic [7:0]   g_sym[PROD_CAP][SYM_CAP];
	int           g_len[PROD_CAP];
	int           g_count, g_wpos;
	logic [255:0] first_s[NT], follow_s[NT];
	logic [25:0]  seen;
	bit           dirty;

	function automatic bit upper(logic [7:0] c);
		return c >= LETTER_A && c < LETTER_A + NT;
	endfunction

	function automatic void add_code(bit fol, int t, logic [7:0] c);
		if (fol ? !follow_s[t][c] : !first_s[t][c]) begin
			if (fol) follow_s[t][c] = 1'b1; else first_s[t][c] = 1'b1;
			dirty = 1;
		end
	endfunction

	function automatic void merge_in(bit fol, int t, logic [255:0] v);
		logic [255:0] d;
		d = fol ? follow_s[t] : first_s[t];
		if ((d | v) != d) begin
			if (fol) follow_s[t] = d | v; else first_s[t] = d | v;
			dirty = 1;
		end
	endfunction

	// Add FIRST of symbols from..end of production p; true when all can vanish
	function automatic bit seq_first(int p, int from, bit fol, int t);
		logic [7:0]   x;
		logic [255:0] v;
		for (int j = from; j < g_len[p]; j++) begin
			x = g_sym[p][j];
			if (x == EPS_CODE) continue;
			if (!upper(x)) begin
				add_code(fol, t, x);
				return 0;
			end
			v = first_s[x - LETTER_A];
			v[EPS_CODE] = 1'b0;
			merge_in(fol, t, v);
			if (!first_s[x - LETTER_A][EPS_CODE]) return 0;
		end
		return 1;
	endfunction

	function automatic void compute_sets();
		int a, b;
		for (int i = 0; i < NT; i++) begin
			first_s[i] = '0;
			follow_s[i] = '0;
		end
		do begin
			dirty = 0;
			for (int p = 0; p < g_count; p++) begin
				if (!upper(g_sym[p][0])) continue;
				a = g_sym[p][0] - LETTER_A;
				if (seq_first(p, 1, 0, a)) add_code(0, a, EPS_CODE);
			end
		end while (dirty);
		if (g_count > 0 && upper(g_sym[0][0])) add_code(1, g_sym[0][0] - LETTER_A, END_CODE);
		do begin
			dirty = 0;
			for (int p = 0; p < g_count; p++) begin
				if (!upper(g_sym[p][0])) continue;
				a = g_sym[p][0] - LETTER_A;
				for (int j = 1; j < g_len[p]; j++) begin
					if (!upper(g_sym[p][j])) continue;
					b = g_sym[p][j] - LETTER_A;
					if (seq_first(p, j + 1, 1, b)) merge_in(1, b, follow_s[a]);
				end
			end
		end while (dirty);
	endfunction

	// Apply one accepted request and queue the chunks it should strobe
	function automatic void predict_chunks(request_t r);
		chunk_t c;
		logic [255:0] s;
		c = '{chunk: '0, idx: '0, lst: 1'b1, isnt: 1'b0, st: ST_OK};
		case (r.m)
			MODE_LOAD: begin
				if (g_count >= PROD_CAP) c.st = ST_FULL;
				else begin
					if (g_wpos < SYM_CAP) begin
						g_sym[g_count][g_wpos] = r.sym;
						g_wpos++;
						if (upper(r.sym)) seen[r.sym - LETTER_A] = 1'b1;
					end else c.st = ST_FULL;
					if (r.eop) begin
						g_len[g_count] = g_wpos;
						g_count++;
						g_wpos = 0;
					end
				end
				chunk_q.push_back(c);
			end
			MODE_COMPUTE: begin
				compute_sets();
				if (g_count == 0) c.st = ST_EMPTY;
				chunk_q.push_back(c);
			end
			MODE_QUERY: begin
				s = (r.nt < NT) ? (r.sel ? follow_s[r.nt] : first_s[r.nt]) : '0;
				for (int k = 0; k < 4; k++) begin
					c.chunk = s[k*64 +: 64];
					c.idx = 2'(k);
					c.lst = (k == 3);
					c.isnt = (r.nt < NT) && seen[r.nt];
					chunk_q.push_back(c);
				end
			end
			default: chunk_q.push_back(c);
		endcase
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, n_results);
		errors++;
	endtask

	task automatic push_req(mode_t m, logic [7:0] s, logic e, logic [4:0] n, logic sl);
		request_t r;
		r = '{m: m, sym: s, eop: e, nt: n, sel: sl};
		pending_q.push_back(r);
	endtask

	function automatic logic [7:0] rand_sym();
		int k;
		k = $urandom_range(0, 9);
		if (k < 5) return LETTER_A + $urandom_range(0, 5);
		if (k < 8) return 8'h61 + $urandom_range(0, 3);
		if (k < 9) return EPS_CODE;
		return $urandom_range(0, 255);
	endfunction

	// Queue one production; left side is mostly a letter
	task automatic push_prod(int len);
		push_req(MODE_LOAD, ($urandom_range(0, 9) == 0) ? rand_sym() : LETTER_A + $urandom_range(0, 5),
			len == 0, $urandom, $urandom);
		for (int j = 1; j <= len; j++) push_req(MODE_LOAD, rand_sym(), j == len, $urandom, $urandom);
	endtask

	task automatic push_query();
		push_req(MODE_QUERY, $urandom, $urandom,
			($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 5), $urandom);
	endtask

	// Clock and reset
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1;
	end

	// Check strobed results and predict on each accepted request
	always @(posedge clk) begin
		took <= arst_n && start && !busy;
		if (arst_n) begin
			if (result_valid) begin
				n_results++;
				if (chunk_q.size() == 0) begin
					$display("MISMATCH unexpected result %0d", n_results);
					errors++;
				end else begin
					chunk_t w;
					w = chunk_q.pop_front();
					if (set_chunk !== w.chunk) report("set_chunk", set_chunk, w.chunk);
					if (chunk_index !== w.idx) report("chunk_index", chunk_index, w.idx);
					if (last !== w.lst) report("last", last, w.lst);
					if (is_nonterminal !== w.isnt) report("is_nonterminal", is_nonterminal, w.isnt);
					if (status !== w.st) report("status", status, w.st);
				end
			end
			if (start && !busy) begin
				predict_chunks(pending_q[0]);
				if (pending_q[0].m == MODE_COMPUTE) n_computes++;
				if (pending_q[0].m == MODE_QUERY) n_queries++;
				accepted++;
			end
		end
	end

	// Drive requests from the pending queue with phase-dependent idling
	always @(negedge clk) begin
		int phase, idle_pct;
		int unsigned rem;
		rem = pending_q.size();
		if (took) begin
			void'(pending_q.pop_front());
			rem--;
		end
		phase = (total_reqs > 0) ? (accepted * 4 / total_reqs) % 4 : 0;
		idle_pct = (phase == 1) ? 70 : (phase == 3) ? 28 : 0;
		if (arst_n && rem > 0 && (start && !took || $urandom_range(0, 99) >= idle_pct)) begin
			request_t r;
			r = pending_q[0];
			start <= 1'b1;
			mode <= r.m;
			symbol <= r.sym;
			end_of_production <= r.eop;
			nonterminal_index <= r.nt;
			set_select <= r.sel;
		end else start <= 1'b0;
	end

	initial begin
		int prods;
		start = 0; mode = MODE_LOAD; symbol = 0; end_of_production = 0;
		nonterminal_index = 0; set_select = 0;
		errors = 0; accepted = 0; n_results = 0; n_computes = 0; n_queries = 0;
		g_count = 0; g_wpos = 0; seen = '0;
		for (int i = 0; i < NT; i++) begin
			first_s[i] = '0;
			follow_s[i] = '0;
		end

		// Empty grammar: query, compute with no productions, unused mode, bad index
		push_req(MODE_QUERY, 8'hFF, 1, 5'd0, 0);
		push_req(MODE_COMPUTE, 8'h00, 0, 5'd0, 0);
		push_req(MODE_NONE, 8'hFF, 1, 5'd31, 1);
		// S -> A B c ; A -> a # A | # ; B -> b
		push_req(MODE_LOAD, "S", 0, 0, 0); push_req(MODE_LOAD, "A", 0, 0, 0);
		push_req(MODE_LOAD, "B", 0, 0, 0); push_req(MODE_LOAD, "c", 1, 0, 0);
		push_req(MODE_LOAD, "A", 0, 0, 0); push_req(MODE_LOAD, "a", 0, 0, 0);
		push_req(MODE_LOAD, EPS_CODE, 0, 0, 0); push_req(MODE_LOAD, "A", 1, 0, 0);
		push_req(MODE_LOAD, "A", 0, 0, 0); push_req(MODE_LOAD, EPS_CODE, 1, 0, 0);
		push_req(MODE_LOAD, "B", 0, 0, 0); push_req(MODE_LOAD, "b", 1, 0, 0);
		// Bad left side, and an open production left unterminated for a compute
		push_req(MODE_LOAD, 8'h00, 0, 0, 0); push_req(MODE_LOAD, "Z", 1, 0, 0);
		push_req(MODE_LOAD, "B", 0, 0, 0); push_req(MODE_LOAD, "Y", 0, 0, 0);
		push_req(MODE_COMPUTE, 0, 0, 0, 0);
		push_req(MODE_QUERY, 0, 0, 5'd18, 1); push_req(MODE_QUERY, 0, 0, 5'd0, 0);
		push_req(MODE_QUERY, 0, 0, 5'd25, 1); push_req(MODE_QUERY, 0, 0, 5'd26, 0);
		push_req(MODE_LOAD, "d", 1, 0, 0);
		prods = 5;

		// Random grammars grown in rounds, each mostly closed by a compute, then queries
		for (int round = 0; round < 2; round++) begin
			repeat ($urandom_range(2, 4)) begin
				push_prod($urandom_range(0, 4));
				prods++;
			end
			if ($urandom_range(0, 3) == 0) push_req(MODE_LOAD, $urandom, $urandom, $urandom, $urandom);
			else push_req(MODE_COMPUTE, $urandom, $urandom, $urandom, $urandom);
			if ($urandom_range(0, 5) == 0) push_req(MODE_NONE, $urandom, $urandom, $urandom, $urandom);
			repeat ($urandom_range(2, 4)) push_query();
		end
		if (pending_q[pending_q.size()-1].m != MODE_COMPUTE) push_req(MODE_COMPUTE, 0, 0, 0, 0);

		// Overlong production, then fill the store and overrun it
		push_req(MODE_LOAD, "C", 0, 0, 0);
		for (int j = 1; j < 34; j++) push_req(MODE_LOAD, rand_sym(), j == 33, 0, 0);
		prods++;
		while (prods < PROD_CAP) begin
			push_prod(0);
			prods++;
		end
		repeat (3) push_req(MODE_LOAD, rand_sym(), 1, 0, 0);
		push_req(MODE_COMPUTE, 0, 0, 0, 0);
		repeat (6) push_query();
		total_reqs = pending_q.size();

		wait (pending_q.size() == 0);
		wait (chunk_q.size() == 0 && !busy);
		repeat (20) @(posedge clk);
		$display("Covered %0d requests (%0d computes, %0d queries), %0d results checked.",
			accepted, n_computes, n_queries, n_results);
		$display("Grammar grew to a full store with an overlong production and dropped loads.");
		if (errors == 0 && chunk_q.size() == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	initial begin
		#50ms;
		$display("TIMEOUT with %0d requests pending", pending_q.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== grammar_first_follow_sets.f =====
rtl/core/gffs_pkg.sv
rtl/core/gffs_ram.sv
rtl/core/gffs_merge.sv
rtl/core/grammar_first_follow_sets.sv
rtl/core/gffs_checker.sv
bench/grammar_first_follow_sets_tb.sv
